// ----- rtl/mwm_pkg.sv -----
// Shared types and constants of the mecanum wheel mixer.
package mwm_pkg;

    // Field widths.
    localparam int unsigned NUM_WHEELS = 4;
    localparam int unsigned W_SPEED    = 16;
    localparam int unsigned W_LIMIT    = 15;
    localparam int unsigned W_IDX      = 3;

    // Configuration register indexes.
    localparam logic [W_IDX-1:0] CFG_LIMIT_FORWARD  = 3'd0;
    localparam logic [W_IDX-1:0] CFG_LIMIT_SIDEWAYS = 3'd1;
    localparam logic [W_IDX-1:0] CFG_LIMIT_TURN     = 3'd2;
    localparam logic [W_IDX-1:0] CFG_WHEEL_LIMIT    = 3'd3;
    localparam logic [W_IDX-1:0] CFG_WHEEL_LAYOUT   = 3'd4;

    // Wheel layout codes.
    localparam logic LAYOUT_STANDARD = 1'b0;
    localparam logic LAYOUT_OLD      = 1'b1;

    // Register reset values.
    localparam logic [W_LIMIT-1:0] LIMIT_RESET = 15'h7FFF;

    typedef logic [W_SPEED-1:0] t_word;
    typedef logic [W_LIMIT-1:0] t_limit;

    // Configuration register set.
    typedef struct packed {
        t_limit limit_forward;
        t_limit limit_sideways;
        t_limit limit_turn;
        t_limit wheel_limit;
        logic   wheel_layout;
    } t_cfg;

    // One item in flight through the scaling divider.
    typedef struct packed {
        logic                           scaled;
        logic [W_SPEED-1:0]             den;
        logic [NUM_WHEELS-1:0]          neg;
        logic [NUM_WHEELS-1:0][15:0]    w;
        logic [NUM_WHEELS-1:0][15:0]    rem;
        logic [NUM_WHEELS-1:0][14:0]    num;
        logic [NUM_WHEELS-1:0][14:0]    quo;
    } t_div_item;

    // One result item; wheel zero sits in the lowest bits.
    typedef struct packed {
        logic                           scaled;
        logic [NUM_WHEELS-1:0][15:0]    wheel;
    } t_result;

endpackage

// ----- rtl/mwm_front.sv -----
// Front stages: clamp, mix, saturate, magnitude, maximum and product.
module mwm_front
    import mwm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_vld,
    input  t_word      i_forward,
    input  t_word      i_sideways,
    input  t_word      i_turn,
    input  t_cfg       i_cfg,
    output logic       o_vld,
    output t_div_item  o_item
);

    // Symmetric clamp of a signed command to a 15-bit limit.
    function automatic t_word clamp_sym(input t_word v, input t_limit lim);
        logic signed [15:0] sv;
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        begin
            sv = $signed(v);
            hi = $signed({1'b0, lim});
            lo = -hi;
            if (sv > hi) begin
                clamp_sym = t_word'(hi);
            end else if (sv < lo) begin
                clamp_sym = t_word'(lo);
            end else begin
                clamp_sym = v;
            end
        end
    endfunction

    // Saturation of a mixed sum to the signed 16-bit range.
    function automatic t_word sat16(input logic signed [17:0] v);
        begin
            if (v > 18'sd32767) begin
                sat16 = 16'h7FFF;
            end else if (v < -18'sd32768) begin
                sat16 = 16'h8000;
            end else begin
                sat16 = v[15:0];
            end
        end
    endfunction

    logic                              r_vld [6];

    t_word                             r1_f, r1_s, r1_t;
    logic [NUM_WHEELS-1:0][15:0]       r2_w;
    logic [NUM_WHEELS-1:0][15:0]       r3_w, r3_mag;
    logic [NUM_WHEELS-1:0]             r3_neg;
    logic [NUM_WHEELS-1:0][15:0]       r4_w, r4_mag;
    logic [NUM_WHEELS-1:0]             r4_neg;
    logic [15:0]                       r4_m01, r4_m23;
    logic [NUM_WHEELS-1:0][15:0]       r5_w, r5_mag;
    logic [NUM_WHEELS-1:0]             r5_neg;
    logic [15:0]                       r5_max;
    logic                              r5_scaled;
    t_div_item                         r6_item;

    logic signed [17:0]                fx, sx, tx;
    logic signed [17:0]                n_sum [NUM_WHEELS];
    logic [15:0]                       n_max;
    t_div_item                         n_item;
    logic [30:0]                       n_prod [NUM_WHEELS];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < 6; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Mixing with the sign pattern of the selected layout.
    always_comb begin
        fx = 18'(signed'(r1_f));
        sx = 18'(signed'(r1_s));
        tx = 18'(signed'(r1_t));
        case (i_cfg.wheel_layout)
            LAYOUT_STANDARD: begin
                n_sum[0] =  fx + sx + tx;
                n_sum[1] = -fx + sx + tx;
                n_sum[2] =  fx - sx + tx;
                n_sum[3] = -fx - sx + tx;
            end
            LAYOUT_OLD: begin
                n_sum[0] = -fx + sx - tx;
                n_sum[1] = -fx - sx - tx;
                n_sum[2] =  fx - sx - tx;
                n_sum[3] =  fx + sx - tx;
            end
            default: begin
                n_sum[0] = '0;
                n_sum[1] = '0;
                n_sum[2] = '0;
                n_sum[3] = '0;
            end
        endcase
    end

    // Largest magnitude from the two pairwise maxima.
    always_comb begin
        n_max = (r4_m01 > r4_m23) ? r4_m01 : r4_m23;
    end

    // Products of each magnitude with the wheel limit start the division.
    always_comb begin
        n_item        = '0;
        n_item.scaled = r5_scaled;
        n_item.den    = r5_max;
        n_item.neg    = r5_neg;
        n_item.w      = r5_w;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            n_prod[k]      = 31'(r5_mag[k] * {1'b0, i_cfg.wheel_limit});
            n_item.rem[k]  = n_prod[k][30:15];
            n_item.num[k]  = n_prod[k][14:0];
            n_item.quo[k]  = '0;
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_f <= clamp_sym(i_forward,  i_cfg.limit_forward);
            r1_s <= clamp_sym(i_sideways, i_cfg.limit_sideways);
            r1_t <= clamp_sym(i_turn,     i_cfg.limit_turn);

            for (int k = 0; k < NUM_WHEELS; k++) begin
                r2_w[k] <= sat16(n_sum[k]);
            end

            r3_w <= r2_w;
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r3_neg[k] <= r2_w[k][15];
                r3_mag[k] <= r2_w[k][15] ? 16'(-r2_w[k]) : r2_w[k];
            end

            r4_w   <= r3_w;
            r4_mag <= r3_mag;
            r4_neg <= r3_neg;
            r4_m01 <= (r3_mag[0] > r3_mag[1]) ? r3_mag[0] : r3_mag[1];
            r4_m23 <= (r3_mag[2] > r3_mag[3]) ? r3_mag[2] : r3_mag[3];

            r5_w      <= r4_w;
            r5_mag    <= r4_mag;
            r5_neg    <= r4_neg;
            r5_max    <= n_max;
            r5_scaled <= n_max > {1'b0, i_cfg.wheel_limit};

            r6_item <= n_item;
        end
    end

    assign o_vld  = r_vld[5];
    assign o_item = r6_item;

endmodule

// ----- rtl/mwm_div_step.sv -----
// One quotient bit of the four-lane restoring divider.
module mwm_div_step
    import mwm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_vld,
    input  t_div_item  i_item,
    output logic       o_vld,
    output t_div_item  o_item
);

    logic      r_vld;
    t_div_item r_item;
    t_div_item n_item;
    logic [16:0] trial [NUM_WHEELS];
    logic        ge    [NUM_WHEELS];

    // Shift in the next numerator bit and subtract the divisor where it fits.
    always_comb begin
        n_item = i_item;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            trial[k] = {i_item.rem[k], i_item.num[k][14]};
            ge[k]    = trial[k] >= {1'b0, i_item.den};
            n_item.rem[k] = ge[k] ? 16'(trial[k] - {1'b0, i_item.den}) : trial[k][15:0];
            n_item.num[k] = {i_item.num[k][13:0], 1'b0};
            n_item.quo[k] = {i_item.quo[k][13:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ----- rtl/mwm_out_buf.sv -----
// Sign restore, output register and skid stage.
module mwm_out_buf
    import mwm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_div_item  i_item,
    output logic       o_en,
    output logic       o_tvalid,
    input  logic       i_tready,
    output t_result    o_data
);

    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;
    logic    n_out_vld, n_skid_vld;
    t_result n_out, n_skid;
    t_result res;
    logic [15:0] qmag [NUM_WHEELS];

    // Scaled wheels take the quotient with the original sign.
    always_comb begin
        res.scaled = i_item.scaled;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            qmag[k] = {1'b0, i_item.quo[k]};
            if (!i_item.scaled) begin
                res.wheel[k] = i_item.w[k];
            end else if (i_item.neg[k]) begin
                res.wheel[k] = 16'(-qmag[k]);
            end else begin
                res.wheel[k] = qmag[k];
            end
        end
    end

    // The skid stage catches the item that leaves the pipeline while the
    // output register is held.
    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (r_out_vld && i_tready) begin
            n_out_vld = 1'b0;
        end
        if (r_skid_vld) begin
            if (i_tready) begin
                n_out_vld  = 1'b1;
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (i_vld) begin
            if (!r_out_vld || i_tready) begin
                n_out_vld = 1'b1;
                n_out     = res;
            end else begin
                n_skid_vld = 1'b1;
                n_skid     = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_en     = ~r_skid_vld;
    assign o_tvalid = r_out_vld;
    assign o_data   = r_out;

endmodule

// ----- rtl/mecanum_wheel_mixer_unit.sv -----
// Top level of the mecanum wheel mixer: configuration registers and pipeline.
//
//  Channel   Direction  Handshake                  Contents
//  s         in         i_s_tvalid / o_s_tready    forward, sideways, turn speed
//  m         out        o_m_tvalid / i_m_tready    four wheel speeds, was_scaled
//  cfg       in         i_cfg_valid / o_cfg_ready  register index and value
//
// One command enters per cycle while o_s_tready is high; a result passes
// through six front stages, the fifteen-stage divider and the output register.
// Reset clears the registers to their defaults and empties the pipeline.
// A held result is caught by a skid stage; the pipeline and o_s_tready stall
// only while that stage is full, so nothing is lost or repeated.
module mecanum_wheel_mixer_unit
    import mwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] speed_forward, [31:16] speed_sideways, [47:32] speed_turn
    input  logic [47:0] i_s_tdata,

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] wheel_zero, [31:16] wheel_one, [47:32] wheel_two,
    // [63:48] wheel_three, [64] was_scaled, [71:65] zero
    output logic [71:0] o_m_tdata,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int unsigned DIV_STAGES = W_LIMIT;

    t_cfg      r_cfg;
    logic      en;
    logic      front_vld;
    t_div_item front_item;
    logic      div_vld  [DIV_STAGES+1];
    t_div_item div_item [DIV_STAGES+1];
    t_result   out_data;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_forward  <= LIMIT_RESET;
            r_cfg.limit_sideways <= LIMIT_RESET;
            r_cfg.limit_turn     <= LIMIT_RESET;
            r_cfg.wheel_limit    <= LIMIT_RESET;
            r_cfg.wheel_layout   <= LAYOUT_STANDARD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LIMIT_FORWARD:  r_cfg.limit_forward  <= i_cfg_data;
                CFG_LIMIT_SIDEWAYS: r_cfg.limit_sideways <= i_cfg_data;
                CFG_LIMIT_TURN:     r_cfg.limit_turn     <= i_cfg_data;
                CFG_WHEEL_LIMIT:    r_cfg.wheel_limit    <= i_cfg_data;
                CFG_WHEEL_LAYOUT:   r_cfg.wheel_layout   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = en;

    // Clamp, mix, saturate, find the largest magnitude and form the products.
    mwm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (i_s_tvalid),
        .i_forward  (i_s_tdata[15:0]),
        .i_sideways (i_s_tdata[31:16]),
        .i_turn     (i_s_tdata[47:32]),
        .i_cfg      (r_cfg),
        .o_vld      (front_vld),
        .o_item     (front_item)
    );

    assign div_vld[0]  = front_vld;
    assign div_item[0] = front_item;

    // Divider: one quotient bit per stage.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        mwm_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (div_vld[g]),
            .i_item  (div_item[g]),
            .o_vld   (div_vld[g+1]),
            .o_item  (div_item[g+1])
        );
    end

    // Sign restore and output buffering.
    mwm_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (div_vld[DIV_STAGES]),
        .i_item   (div_item[DIV_STAGES]),
        .o_en     (en),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_data   (out_data)
    );

    assign o_m_tdata = {7'b0, out_data};

endmodule
